@@ hdl/txc_pkg.sv @@
package txc_pkg;

	localparam int COLS  = 80;
	localparam int ROWS  = 25;
	localparam int CELLS = COLS * ROWS;

	// cell address and cursor widths (cursor may sit one past the last cell)
	localparam int AW = $clog2(CELLS);
	localparam int CW = $clog2(CELLS + 1);

	// fixed field widths
	localparam int MODE_W = 2;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 11;
	localparam int CELL_W = 2 * BYTE_W;

	localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SETCUR = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

	localparam logic [BYTE_W-1:0] NEWLINE    = 8'h0A;
	localparam logic [BYTE_W-1:0] BLANK_ATTR = 8'h0F;
	// cell word is {char, attr}
	localparam logic [CELL_W-1:0] BLANK_CELL = {8'h00, BLANK_ATTR};

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_SCROLL,
		S_SDRAIN,
		S_BLANK,
		S_ROWFIND,
		S_READ,
		S_EMIT
	} state_t;

endpackage

@@ hdl/text_console_cursor_scroll.sv @@
// Text console engine: a COLS x ROWS screen of {char, attr} cells in one
// synchronous RAM plus a cell-counting cursor.
// Request channel (req_valid / req_stall): one beat carries mode, char_code,
// attribute and position, taken when req_valid is high and req_stall low. One
// request at a time; req_stall is high from the accepting edge until the
// result has moved into the output register.
// Response channel (rsp_valid / rsp_stall): one beat per request, held in an
// output register, so a new request is taken while a response waits under
// rsp_stall. A stalled response does not change; a finished request then
// waits in the emit state until the register frees.
// Steps from accept to response valid, with no stall:
//   put / newline without scroll : dispatch, emit
//   read cell : dispatch, read (RAM read data captured), emit
//   set cursor : row start found one row a cycle   clear : every cell blanked
//   a scrolling newline adds the row copy one cell a cycle, a drain state and
//   last row blanking; a scrolling character then goes back to dispatch.
// Reset: the cursor homes and a clearing pass writes a blank cell (char 0,
// attr 0x0F) to every entry, one a cycle; req_stall stays high.
module text_console_cursor_scroll
	import txc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [BYTE_W-1:0] char_code,
	input  logic [BYTE_W-1:0] attribute,
	input  logic [POS_W-1:0]  position,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [BYTE_W-1:0] cell_char,
	output logic [BYTE_W-1:0] cell_attr,
	output logic [POS_W-1:0]  cursor_cell,
	output logic              scrolled
);

	state_t state_q, state_d;

	// captured request
	logic [MODE_W-1:0] mode_q;
	logic [BYTE_W-1:0] char_q;
	logic [BYTE_W-1:0] attr_q;
	logic [POS_W-1:0]  pos_q;

	// cursor and the start of its row (CELLS when cursor is at screen end)
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] rb_q;

	logic [AW-1:0] ptr_q;        // blank sweep pointer
	logic [AW-1:0] src_q;        // scroll copy read pointer
	logic          cp_valid_s1;  // copy write pending
	logic [AW-1:0] cp_dst_s1;

	logic              scr_q;
	logic [BYTE_W-1:0] rd_char_q;
	logic [BYTE_W-1:0] rd_attr_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_char_q;
	logic [BYTE_W-1:0] out_attr_q;
	logic [POS_W-1:0]  out_cursor_q;
	logic              out_scr_q;

	// screen RAM
	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CELL_W-1:0] mem_wd;
	logic [AW-1:0]     mem_ra;

	// decode
	logic          accept;
	logic          is_nl;
	logic          at_end;
	logic          last_row;
	logic          ptr_last;
	logic          out_free;
	logic [CW:0]   rb_next;
	logic [CW-1:0] cur_inc;
	logic [CW-1:0] set_target;
	logic [AW-1:0] rd_idx;

	assign accept   = req_valid && (state_q == S_IDLE);
	assign is_nl    = (char_q == NEWLINE);
	assign at_end   = (cursor_q == CW'(CELLS));
	assign last_row = (rb_q >= CW'(CELLS - COLS));
	assign ptr_last = (ptr_q == AW'(CELLS - 1));
	assign out_free = !out_valid_q || !rsp_stall;
	assign rb_next  = {1'b0, rb_q} + (CW+1)'(COLS);
	assign cur_inc  = cursor_q + CW'(1);

	always_comb begin
		if ({1'b0, pos_q} > (POS_W+1)'(CELLS)) begin
			set_target = CW'(CELLS);
		end else begin
			set_target = CW'(pos_q);
		end
		if ({1'b0, pos_q} >= (POS_W+1)'(CELLS)) begin
			rd_idx = AW'(CELLS - 1);
		end else begin
			rd_idx = AW'(pos_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (ptr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (mode_q)
					MODE_PUT: begin
						if (is_nl) state_d = last_row ? S_SCROLL : S_EMIT;
						else       state_d = at_end ? S_SCROLL : S_EMIT;
					end
					MODE_CLEAR:  state_d = S_BLANK;
					MODE_SETCUR: state_d = S_ROWFIND;
					default:     state_d = S_READ;
				endcase
			end
			S_SCROLL: begin
				if (src_q == AW'(CELLS - 1)) state_d = S_SDRAIN;
			end
			S_SDRAIN: state_d = S_BLANK;
			S_BLANK: begin
				// a character put after a scroll goes back to write the cell
				if (ptr_last) begin
					if (mode_q == MODE_CLEAR || is_nl) state_d = S_EMIT;
					else                               state_d = S_DISPATCH;
				end
			end
			S_ROWFIND: begin
				if (rb_next > {1'b0, cursor_q}) state_d = S_EMIT;
			end
			S_READ: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = BLANK_CELL;
		mem_ra = src_q;
		case (state_q)
			S_INIT, S_BLANK: begin
				mem_we = 1'b1;
			end
			S_SCROLL, S_SDRAIN: begin
				mem_we = cp_valid_s1;
				mem_wa = cp_dst_s1;
				mem_wd = rdata_q;
			end
			S_DISPATCH: begin
				mem_ra = rd_idx;
				if (mode_q == MODE_PUT && !is_nl && !at_end) begin
					mem_we = 1'b1;
					mem_wa = AW'(cursor_q);
					mem_wd = {char_q, attr_q};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cursor_q    <= '0;
			rb_q        <= '0;
			ptr_q       <= '0;
			src_q       <= '0;
			cp_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cp_valid_s1 <= (state_q == S_SCROLL);
			cp_dst_s1   <= src_q - AW'(COLS);

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q    <= mode;
						char_q    <= char_code;
						attr_q    <= attribute;
						pos_q     <= position;
						scr_q     <= 1'b0;
						rd_char_q <= '0;
						rd_attr_q <= '0;
					end
				end
				S_DISPATCH: begin
					case (mode_q)
						MODE_PUT: begin
							src_q <= AW'(COLS);
							ptr_q <= AW'(CELLS - COLS);
							if (is_nl && !last_row) begin
								cursor_q <= CW'(rb_next);
								rb_q     <= CW'(rb_next);
							end else if (!is_nl && !at_end) begin
								cursor_q <= cur_inc;
								if ({1'b0, cur_inc} == rb_next) rb_q <= CW'(rb_next);
							end
						end
						MODE_CLEAR: begin
							ptr_q    <= '0;
							cursor_q <= '0;
							rb_q     <= '0;
						end
						MODE_SETCUR: begin
							cursor_q <= set_target;
							rb_q     <= '0;
						end
						default: begin
						end
					endcase
				end
				S_SCROLL: begin
					src_q <= src_q + AW'(1);
				end
				S_INIT: begin
					ptr_q <= ptr_q + AW'(1);
				end
				S_BLANK: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_last && mode_q != MODE_CLEAR) begin
						cursor_q <= CW'(CELLS - COLS);
						rb_q     <= CW'(CELLS - COLS);
						scr_q    <= 1'b1;
					end
				end
				S_ROWFIND: begin
					if (rb_next <= {1'b0, cursor_q}) rb_q <= CW'(rb_next);
				end
				S_READ: begin
					rd_char_q <= rdata_q[CELL_W-1:BYTE_W];
					rd_attr_q <= rdata_q[BYTE_W-1:0];
				end
				default: begin
				end
			endcase

			// output register
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_char_q   <= rd_char_q;
			out_attr_q   <= rd_attr_q;
			out_cursor_q <= POS_W'(cursor_q);
			out_scr_q    <= scr_q;
		end
	end

	assign req_stall   = (state_q != S_IDLE);
	assign rsp_valid   = out_valid_q;
	assign cell_char   = out_char_q;
	assign cell_attr   = out_attr_q;
	assign cursor_cell = out_cursor_q;
	assign scrolled    = out_scr_q;

	// row start tracks the cursor whenever idle
	a_row_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (rb_q <= cursor_q) &&
			(({1'b0, cursor_q} < rb_next) || (rb_q == CW'(CELLS))))
		else $error("row base out of step with cursor");

	// copy writes only follow a scroll read
	a_copy_src: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid_s1 |-> $past(state_q == S_SCROLL))
		else $error("copy write without scroll read");

	// an accepted request is dispatched next cycle
	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_DISPATCH))
		else $error("accepted request not dispatched");

endmodule

@@ tb/tb_text_console_cursor_scroll.sv @@
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll;
	import txc_pkg::*;

	// Random beats after the directed opening.
	localparam int RANDOM_BEATS = 1000;
	// Bound per request, well above a put that scrolls (copy and blank of the screen).
	localparam int WORST_BEAT_CYCLES = 2 * CELLS + 8;
	// Worst case for the whole run, with stalls and gaps, then taken four times over.
	// The clearing pass after reset is included.
	localparam longint LIMIT_NS =
		64'd4 * 64'd10 * ((RANDOM_BEATS + 40) * (WORST_BEAT_CYCLES + 200) + CELLS);

	// One response beat, in port order.
	typedef struct packed {
		logic [BYTE_W-1:0] chr;
		logic [BYTE_W-1:0] attr;
		logic [POS_W-1:0]  cur;
		logic              scr;
	} console_rsp_t;

	// Screen model and store of responses still due.
	class console_scoreboard;
		logic [CELL_W-1:0] screen [CELLS];
		int unsigned       cursor_pos;
		console_rsp_t      pending_rsp [$];
		int unsigned       errors;

		function new();
			errors = 0;
			blank_screen();
		endfunction

		function void blank_screen();
			for (int i = 0; i < CELLS; i++)
				screen[i] = BLANK_CELL;
			cursor_pos = 0;
		endfunction

		// Rows move up one, the last row is blanked, the cursor goes to its start.
		function void scroll_up();
			for (int i = 0; i < CELLS - COLS; i++)
				screen[i] = screen[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				screen[i] = BLANK_CELL;
			cursor_pos = CELLS - COLS;
		endfunction

		// Request beat taken: update the screen and work out its response.
		function void note_request(input logic [MODE_W-1:0] md,
				input logic [BYTE_W-1:0] ch, at, input logic [POS_W-1:0] pos);
			console_rsp_t r;
			int unsigned  idx;
			r = '0;
			case (md)
				MODE_PUT: begin
					if (ch == NEWLINE) begin
						if (cursor_pos >= CELLS - COLS) begin
							scroll_up();
							r.scr = 1'b1;
						end else begin
							cursor_pos = cursor_pos - cursor_pos % COLS + COLS;
						end
					end else begin
						if (cursor_pos >= CELLS) begin
							scroll_up();
							r.scr = 1'b1;
						end
						screen[cursor_pos] = {ch, at};
						cursor_pos++;
					end
				end
				MODE_CLEAR: blank_screen();
				MODE_SETCUR: cursor_pos = (pos > CELLS) ? CELLS : pos;
				MODE_READ: begin
					idx = (pos >= CELLS) ? CELLS - 1 : pos;
					{r.chr, r.attr} = screen[idx];
				end
				default: begin
				end
			endcase
			r.cur = cursor_pos[POS_W-1:0];
			pending_rsp.push_back(r);
		endfunction

		function void compare(input string field, input logic [15:0] want, got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		// Response beat taken: compare with the oldest response due.
		function void check_response(input console_rsp_t got);
			console_rsp_t want;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response beat with none due, expected nothing got %0h",
					$time, got);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			compare("cell_char", want.chr, got.chr);
			compare("cell_attr", want.attr, got.attr);
			compare("cursor_cell", want.cur, got.cur);
			compare("scrolled", want.scr, got.scr);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [MODE_W-1:0] mode = MODE_PUT;
	logic [BYTE_W-1:0] char_code = '0;
	logic [BYTE_W-1:0] attribute = '0;
	logic [POS_W-1:0]  position = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic [BYTE_W-1:0] cell_char;
	logic [BYTE_W-1:0] cell_attr;
	logic [POS_W-1:0]  cursor_cell;
	logic              scrolled;

	// Idle rates in percent, changed per phase of the run.
	int unsigned send_idle_pct = 12;
	int unsigned rcv_idle_pct = 62;

	console_scoreboard sb = new();

	text_console_cursor_scroll dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.mode        (mode),
		.char_code   (char_code),
		.attribute   (attribute),
		.position    (position),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.cell_char   (cell_char),
		.cell_attr   (cell_attr),
		.cursor_cell (cursor_cell),
		.scrolled    (scrolled)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure, redrawn every falling edge.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	// Both channels are watched at the rising edge; a beat moves when valid is
	// high and stall low. An X on rsp_valid counts as a beat so it gets flagged.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_stall === 1'b0)
				sb.note_request(mode, char_code, attribute, position);
			if (rsp_valid !== 1'b0 && rsp_stall === 1'b0)
				sb.check_response({cell_char, cell_attr, cursor_cell, scrolled});
		end
	end

	// Offer one request beat and hold it until taken. Called at a falling edge,
	// returns at the falling edge after the accepting rising edge. Valid stays
	// high between back-to-back beats.
	task automatic send_beat(input logic [MODE_W-1:0] md, input logic [BYTE_W-1:0] ch,
			input logic [BYTE_W-1:0] at, input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		mode      <= md;
		char_code <= ch;
		attribute <= at;
		position  <= pos;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Random request. Set-cursor beats lean towards the bottom of the screen so
	// that newlines and wrapping puts scroll often; reads lean towards the cells
	// just behind the cursor, where the written text sits.
	task automatic random_beat();
		int unsigned       pick;
		logic [MODE_W-1:0] md;
		logic [BYTE_W-1:0] ch;
		logic [BYTE_W-1:0] at;
		logic [POS_W-1:0]  pos;
		pick = $urandom_range(99);
		ch   = BYTE_W'($urandom_range(255));
		at   = BYTE_W'($urandom_range(255));
		pos  = POS_W'($urandom_range(2047));
		if (pick < 56) begin
			md = MODE_PUT;
			if ($urandom_range(9) == 0)
				ch = NEWLINE;
		end else if (pick < 58) begin
			md = MODE_CLEAR;
		end else if (pick < 76) begin
			md = MODE_SETCUR;
			if ($urandom_range(2) == 0)
				pos = POS_W'($urandom_range(2047, CELLS - COLS - 20));
		end else begin
			md = MODE_READ;
			if ($urandom_range(1) == 0)
				pos = POS_W'((sb.cursor_pos > 40) ? sb.cursor_pos - $urandom_range(40)
					: $urandom_range(40));
		end
		send_beat(md, ch, at, pos);
	endtask

	initial begin
		#(LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		// Reset held from time zero, released on a falling edge. The block then
		// runs its clearing pass with req_stall high; send_beat just waits it out.
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed opening.
		send_beat(MODE_READ, 8'h00, 8'h00, 11'd0);              // blank cell after reset
		send_beat(MODE_READ, 8'h00, 8'h00, 11'h7FF);            // clamps to last cell
		send_beat(MODE_PUT, 8'h41, 8'hFF, 11'd0);
		send_beat(MODE_PUT, 8'hFF, 8'h00, 11'h7FF);
		send_beat(MODE_PUT, 8'h00, 8'h80, 11'd0);
		send_beat(MODE_PUT, NEWLINE, 8'h12, 11'd0);             // row 0 -> row 1
		send_beat(MODE_READ, 8'h00, 8'h00, 11'd1);
		send_beat(MODE_SETCUR, 8'h00, 8'h00, 11'h7FF);          // saturates at screen end
		send_beat(MODE_PUT, 8'h5A, 8'h55, 11'd0);               // scroll, then write
		send_beat(MODE_READ, 8'h00, 8'h00, POS_W'(CELLS - COLS));
		send_beat(MODE_READ, 8'h00, 8'h00, POS_W'(CELLS - COLS - 1));
		send_beat(MODE_SETCUR, 8'h00, 8'h00, POS_W'(CELLS - 1));
		send_beat(MODE_PUT, 8'hAA, 8'hAA, 11'd0);               // cursor lands on screen end
		send_beat(MODE_PUT, NEWLINE, 8'h00, 11'd0);             // newline at screen end scrolls
		send_beat(MODE_SETCUR, 8'h00, 8'h00, POS_W'(CELLS - COLS));
		send_beat(MODE_PUT, NEWLINE, 8'h00, 11'd0);             // newline on last row scrolls
		send_beat(MODE_SETCUR, 8'h00, 8'h00, POS_W'(CELLS - COLS - 1));
		send_beat(MODE_PUT, NEWLINE, 8'h00, 11'd0);             // no scroll, to last row
		send_beat(MODE_SETCUR, 8'h00, 8'h00, POS_W'(CELLS));    // exactly screen end
		send_beat(MODE_SETCUR, 8'h00, 8'h00, POS_W'(COLS - 1));
		send_beat(MODE_PUT, NEWLINE, 8'h00, 11'd0);
		send_beat(MODE_READ, 8'h00, 8'h00, POS_W'(CELLS - COLS - 1));
		send_beat(MODE_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
		send_beat(MODE_READ, 8'h00, 8'h00, POS_W'(CELLS - 1));

		// Random part in three idling phases.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == RANDOM_BEATS / 3) begin
				send_idle_pct = 62;
				rcv_idle_pct  = 12;
			end else if (i == 2 * RANDOM_BEATS / 3) begin
				send_idle_pct = 0;
				rcv_idle_pct  = 0;
			end
			random_beat();
		end
		req_valid <= 1'b0;

		// Drain, then linger long enough to catch any stray response beat.
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (WORST_BEAT_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ text_console_cursor_scroll.f @@
hdl/txc_pkg.sv
hdl/text_console_cursor_scroll.sv
tb/tb_text_console_cursor_scroll.sv
